### rtl/wsts_pkg.sv
package wsts_pkg;
  localparam int Workers = 8;
  localparam int Tasks = 256;
  localparam int WBits = $clog2(Workers);
  localparam int TBits = $clog2(Tasks);
  localparam int DBits = TBits + 1;
  localparam int ABits = WBits + TBits;
  localparam int Depth = Workers * Tasks;

  localparam logic [1:0] K_PUSH_STEAL = 2'd0;
  localparam logic [1:0] K_PUSH_SPEC = 2'd1;
  localparam logic [1:0] K_POP = 2'd2;
  localparam logic [1:0] K_STEAL = 2'd3;

  localparam logic [2:0] OC_OK = 3'd0;
  localparam logic [2:0] OC_EMPTY = 3'd1;
  localparam logic [2:0] OC_FULL = 3'd2;
  localparam logic [2:0] OC_SINGLE = 3'd3;
  localparam logic [2:0] OC_NO_STATUS = 3'd4;
  localparam logic [2:0] OC_HAS_WORK = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_POPRD, S_CPRD, S_CPWR, S_SHRD, S_SHWR, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [15:0] task_out;
    logic from_specific;
    logic [7:0] moved_count;
    logic [2:0] victim;
  } res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] worker;
    logic [15:0] task_in;
    logic has_status;
  } req_t;
endpackage

### rtl/wsts_if.sv
interface wsts_req_if;
  logic valid;
  logic ready;
  wsts_pkg::req_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface wsts_res_if;
  logic valid;
  logic ready;
  wsts_pkg::res_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/work_stealing_task_stacks.sv
// Work-stealing task stacks, one request at a time. Each of the eight workers
// owns a specific and a stealable stack of 256 handles, held in two memories
// with a registered read, and the per-worker depth counts are held in
// registers. A push or a pop passes from the idle state through S_POPRD to
// S_OUT, which loads the result register once it is free, and the core then
// returns to idle for the next request. A successful steal from a victim
// holding d stealable tasks moves each task with one read and one write of
// the stealable memory, first the copy of the bottom half to the thief, then
// the shift down of the victim's remainder, and then loads the result in
// S_OUT in the same way. A result left waiting in the output register does
// not hold off the next request; the core only waits in its output state
// while that register is still full.
module work_stealing_task_stacks (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [3:0] cfg_wdata,
  wsts_req_if.sink req,
  wsts_res_if.source res
);
  localparam int WB = wsts_pkg::WBits;
  localparam int TB = wsts_pkg::TBits;
  localparam int DB = wsts_pkg::DBits;
  localparam int AB = wsts_pkg::ABits;

  wsts_pkg::state_t state, state_next;
  logic [3:0] active_workers;
  logic [DB-1:0] spec_d [wsts_pkg::Workers];
  logic [DB-1:0] steal_d [wsts_pkg::Workers];
  wsts_pkg::req_t r;
  wsts_pkg::res_t out;
  wsts_pkg::res_t res_word;
  logic [WB-1:0] vic;
  logic [DB-1:0] cnt, rem, idx;
  logic [WB-1:0] w;
  logic [DB-1:0] cur_d;
  logic [4:0] eff;
  logic found;
  logic vic_ok;
  logic [WB-1:0] fvic;
  logic acc;
  logic act;
  logic push_ok;
  logic steal_go;
  logic res_free;

  logic sp_we, st_we;
  logic [AB-1:0] sp_wa, sp_ra, st_wa, st_ra;
  logic [15:0] sp_wd, st_wd, sp_rd, st_rd;

  wsts_ram #(.Width(16), .Depth(wsts_pkg::Depth)) u_spec (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_rd));
  wsts_ram #(.Width(16), .Depth(wsts_pkg::Depth)) u_steal (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

  assign eff = (active_workers > 4'(wsts_pkg::Workers)) ? 5'(wsts_pkg::Workers)
                                                         : {1'b0, active_workers};
  assign w = r.worker[WB-1:0];

  always_comb begin
    found = 1'b0;
    fvic = '0;
    for (int v = wsts_pkg::Workers - 1; v >= 0; v--) begin
      if (5'(v) < eff && WB'(v) != req.data.worker[WB-1:0] && steal_d[v] != '0) begin
        found = 1'b1;
        fvic = WB'(v);
      end
    end
  end

  assign req.ready = (state == wsts_pkg::S_IDLE);
  assign acc = req.valid && req.ready;
  assign res_free = !res.valid || res.ready;

  assign act = 5'(r.worker) < eff;
  assign cur_d = (r.kind == wsts_pkg::K_PUSH_SPEC) ? spec_d[w] : steal_d[w];
  assign push_ok = act && (r.kind inside {wsts_pkg::K_PUSH_STEAL, wsts_pkg::K_PUSH_SPEC})
                   && eff >= 5'd2 && cur_d != DB'(wsts_pkg::Tasks) && r.has_status;
  assign steal_go = act && r.kind == wsts_pkg::K_STEAL && steal_d[w] == '0 && vic_ok;

  always_comb begin
    state_next = state;
    case (state)
      wsts_pkg::S_IDLE: if (acc) state_next = wsts_pkg::S_POPRD;
      wsts_pkg::S_POPRD: state_next = steal_go ? wsts_pkg::S_CPRD : wsts_pkg::S_OUT;
      wsts_pkg::S_CPRD: state_next = wsts_pkg::S_CPWR;
      wsts_pkg::S_CPWR: begin
        state_next = (idx + 1'b1 == cnt) ? ((rem == '0) ? wsts_pkg::S_OUT
                                                       : wsts_pkg::S_SHRD)
                                         : wsts_pkg::S_CPRD;
      end
      wsts_pkg::S_SHRD: state_next = wsts_pkg::S_SHWR;
      wsts_pkg::S_SHWR: state_next = (idx + 1'b1 == rem) ? wsts_pkg::S_OUT : wsts_pkg::S_SHRD;
      wsts_pkg::S_OUT: state_next = res_free ? wsts_pkg::S_IDLE : wsts_pkg::S_OUT;
      default: state_next = wsts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sp_we = 1'b0; st_we = 1'b0;
    sp_wa = {w, r.kind == wsts_pkg::K_PUSH_SPEC ? spec_d[w][TB-1:0] : steal_d[w][TB-1:0]};
    st_wa = sp_wa;
    sp_wd = r.task_in; st_wd = r.task_in;
    sp_ra = {w, TB'(spec_d[w] - 1'b1)};
    st_ra = {w, TB'(steal_d[w] - 1'b1)};
    case (state)
      wsts_pkg::S_POPRD: begin
        if (push_ok) begin
          if (r.kind == wsts_pkg::K_PUSH_SPEC) sp_we = 1'b1;
          else st_we = 1'b1;
        end
      end
      wsts_pkg::S_CPRD: st_ra = {vic, idx[TB-1:0]};
      wsts_pkg::S_CPWR: begin
        st_we = 1'b1; st_wa = {w, idx[TB-1:0]}; st_wd = st_rd;
      end
      wsts_pkg::S_SHRD: st_ra = {vic, TB'(idx + cnt)};
      wsts_pkg::S_SHWR: begin
        st_we = 1'b1; st_wa = {vic, idx[TB-1:0]}; st_wd = st_rd;
      end
      wsts_pkg::S_OUT: begin
        // hold the popped entry on the read port while the result waits
        sp_ra = {w, spec_d[w][TB-1:0]};
        st_ra = {w, steal_d[w][TB-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    res_word = out;
    if (out.outcome == wsts_pkg::OC_OK && r.kind == wsts_pkg::K_POP)
      res_word.task_out = out.from_specific ? sp_rd : st_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsts_pkg::S_IDLE;
      active_workers <= 4'd1;
      res.valid <= 1'b0;
      for (int i = 0; i < wsts_pkg::Workers; i++) begin
        spec_d[i] <= '0;
        steal_d[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) active_workers <= cfg_wdata;
      if (state == wsts_pkg::S_OUT && res_free) res.valid <= 1'b1;
      else if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        wsts_pkg::S_IDLE: if (acc) begin
          r <= req.data;
          out <= '{outcome: wsts_pkg::OC_EMPTY, default: '0};
          vic <= fvic;
          vic_ok <= found;
          cnt <= DB'((steal_d[fvic] + 1'b1) >> 1);
          rem <= DB'(steal_d[fvic] - ((steal_d[fvic] + 1'b1) >> 1));
          idx <= '0;
        end
        wsts_pkg::S_POPRD: begin
          if (act) begin
            case (r.kind)
              wsts_pkg::K_PUSH_STEAL, wsts_pkg::K_PUSH_SPEC: begin
                if (eff < 5'd2) out.outcome <= wsts_pkg::OC_SINGLE;
                else if (cur_d == DB'(wsts_pkg::Tasks)) out.outcome <= wsts_pkg::OC_FULL;
                else if (!r.has_status) out.outcome <= wsts_pkg::OC_NO_STATUS;
                else begin
                  out.outcome <= wsts_pkg::OC_OK;
                  if (r.kind == wsts_pkg::K_PUSH_SPEC) spec_d[w] <= spec_d[w] + 1'b1;
                  else steal_d[w] <= steal_d[w] + 1'b1;
                end
              end
              wsts_pkg::K_POP: begin
                if (spec_d[w] != '0) begin
                  spec_d[w] <= spec_d[w] - 1'b1;
                  out.outcome <= wsts_pkg::OC_OK;
                  out.from_specific <= 1'b1;
                end else if (steal_d[w] != '0) begin
                  steal_d[w] <= steal_d[w] - 1'b1;
                  out.outcome <= wsts_pkg::OC_OK;
                end
              end
              default: begin
                if (steal_d[w] != '0) out.outcome <= wsts_pkg::OC_HAS_WORK;
                else if (vic_ok) begin
                  out.outcome <= wsts_pkg::OC_OK;
                  out.moved_count <= 8'(cnt);
                  out.victim <= 3'(vic);
                  steal_d[w] <= cnt;
                  steal_d[vic] <= rem;
                end
              end
            endcase
          end
        end
        wsts_pkg::S_CPWR: idx <= (idx + 1'b1 == cnt) ? '0 : idx + 1'b1;
        wsts_pkg::S_SHWR: idx <= idx + 1'b1;
        wsts_pkg::S_OUT: if (res_free) res.data <= res_word;
        default: ;
      endcase
    end
  end
endmodule

### rtl/wsts_ram.sv
module wsts_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  class task_stack_board;
    logic [15:0] spec_mem[wsts_pkg::Workers][wsts_pkg::Tasks];
    logic [15:0] steal_mem[wsts_pkg::Workers][wsts_pkg::Tasks];
    int spec_cnt[wsts_pkg::Workers];
    int steal_cnt[wsts_pkg::Workers];
    int active;
    wsts_pkg::res_t expected_q[$];
    int errors;
    int n_ok_pop;
    int n_steal;
    int n_full;
    int n_checked;

    function new();
      active = 1;
      errors = 0;
      n_ok_pop = 0;
      n_steal = 0;
      n_full = 0;
      n_checked = 0;
      foreach (spec_cnt[i]) begin
        spec_cnt[i] = 0;
        steal_cnt[i] = 0;
      end
    endfunction

    function void set_active(int v);
      active = v;
    endfunction

    function int shared_workers();
      return (active > wsts_pkg::Workers) ? wsts_pkg::Workers : active;
    endfunction

    function bit pending();
      return expected_q.size() != 0;
    endfunction

    function logic [2:0] push_to(bit to_steal, int w, logic [15:0] t, logic st);
      int d;
      d = to_steal ? steal_cnt[w] : spec_cnt[w];
      if (shared_workers() < 2) return wsts_pkg::OC_SINGLE;
      if (d >= wsts_pkg::Tasks) return wsts_pkg::OC_FULL;
      if (!st) return wsts_pkg::OC_NO_STATUS;
      if (to_steal) begin
        steal_mem[w][d] = t;
        steal_cnt[w] = d + 1;
      end else begin
        spec_mem[w][d] = t;
        spec_cnt[w] = d + 1;
      end
      return wsts_pkg::OC_OK;
    endfunction

    function void note(wsts_pkg::req_t r);
      wsts_pkg::res_t e;
      int n;
      int w;
      int d;
      int cnt;
      e = '0;
      e.outcome = wsts_pkg::OC_EMPTY;
      n = shared_workers();
      w = r.worker;
      if (w < n) begin
        case (r.kind)
          wsts_pkg::K_PUSH_STEAL: e.outcome = push_to(1'b1, w, r.task_in, r.has_status);
          wsts_pkg::K_PUSH_SPEC: e.outcome = push_to(1'b0, w, r.task_in, r.has_status);
          wsts_pkg::K_POP: begin
            if (spec_cnt[w] > 0) begin
              spec_cnt[w]--;
              e.task_out = spec_mem[w][spec_cnt[w]];
              e.from_specific = 1'b1;
              e.outcome = wsts_pkg::OC_OK;
            end else if (steal_cnt[w] > 0) begin
              steal_cnt[w]--;
              e.task_out = steal_mem[w][steal_cnt[w]];
              e.outcome = wsts_pkg::OC_OK;
            end
          end
          default: begin
            if (steal_cnt[w] != 0) begin
              e.outcome = wsts_pkg::OC_HAS_WORK;
            end else begin
              for (int v = 0; v < n; v++) begin
                if (v != w && steal_cnt[v] != 0) begin
                  d = steal_cnt[v];
                  cnt = (d + 1) / 2;
                  for (int i = 0; i < cnt; i++) steal_mem[w][i] = steal_mem[v][i];
                  for (int i = cnt; i < d; i++) steal_mem[v][i - cnt] = steal_mem[v][i];
                  steal_cnt[w] = cnt;
                  steal_cnt[v] = d - cnt;
                  e.outcome = wsts_pkg::OC_OK;
                  e.moved_count = cnt[7:0];
                  e.victim = v[2:0];
                  break;
                end
              end
            end
          end
        endcase
      end
      if (e.outcome == wsts_pkg::OC_FULL) n_full++;
      if (r.kind == wsts_pkg::K_POP && e.outcome == wsts_pkg::OC_OK) n_ok_pop++;
      if (r.kind == wsts_pkg::K_STEAL && e.outcome == wsts_pkg::OC_OK) n_steal++;
      expected_q.insert(expected_q.size(), e);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h", n_checked, what, got, want);
      errors++;
    endtask

    task check(wsts_pkg::res_t g);
      wsts_pkg::res_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, outcome", 16'(g.outcome), 16'(wsts_pkg::OC_EMPTY));
      end else begin
        e = expected_q.pop_front();
        if (g.outcome !== e.outcome) report("outcome", 16'(g.outcome), 16'(e.outcome));
        if (g.task_out !== e.task_out) report("task_out", g.task_out, e.task_out);
        if (g.from_specific !== e.from_specific)
          report("from_specific", 16'(g.from_specific), 16'(e.from_specific));
        if (g.moved_count !== e.moved_count)
          report("moved_count", 16'(g.moved_count), 16'(e.moved_count));
        if (g.victim !== e.victim) report("victim", 16'(g.victim), 16'(e.victim));
      end
      n_checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_wdata;

  wsts_req_if req_if ();
  wsts_res_if res_if ();

  work_stealing_task_stacks dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_if),
    .res(res_if)
  );

  task_stack_board board;
  int burst_left;
  int idle_cycles;
  int cyc;
  int items_sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) board.note(req_if.data);
      if (res_if.valid && res_if.ready) board.check(res_if.data);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // hold ready high for long stretches, then stall on a periodic pattern, then at random, in rotation
  always @(negedge clk) begin
    cyc++;
    if ((cyc / 400) % 3 == 0)
      res_if.ready = 1'b1;
    else if ((cyc / 400) % 3 == 1)
      res_if.ready = (cyc % 7) < 4;
    else
      res_if.ready = ($urandom_range(0, 9) < 3);
  end

  task automatic put(input wsts_pkg::req_t r);
    @(negedge clk);
    if (burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_if.valid = 1'b1;
    req_if.data = r;
    burst_left--;
    items_sent++;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic req_op(logic [1:0] k, int w, logic [15:0] t, logic st);
    wsts_pkg::req_t r;
    r.kind = k;
    r.worker = w[2:0];
    r.task_in = t;
    r.has_status = st;
    put(r);
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    burst_left = 0;
    while (board.pending()) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_workers(int v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v[3:0];
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_active(v);
  endtask

  task automatic random_run(int count);
    int lim;
    int pick;
    int w;
    lim = board.shared_workers();
    if (lim < 1) lim = 1;
    for (int i = 0; i < count; i++) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, lim - 1);
      pick = $urandom_range(0, 99);
      if (pick < 30)
        req_op(wsts_pkg::K_PUSH_STEAL, w, 16'($urandom_range(0, 65535)),
               $urandom_range(0, 15) != 0);
      else if (pick < 50)
        req_op(wsts_pkg::K_PUSH_SPEC, w, 16'($urandom_range(0, 65535)),
               $urandom_range(0, 15) != 0);
      else if (pick < 78)
        req_op(wsts_pkg::K_POP, w, 16'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)));
      else
        req_op(wsts_pkg::K_STEAL, w, 16'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    burst_left = 0;
    idle_cycles = 0;
    cyc = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single worker after reset
    req_op(wsts_pkg::K_PUSH_STEAL, 0, 16'h1234, 1'b1);
    req_op(wsts_pkg::K_PUSH_SPEC, 0, 16'h5678, 1'b1);
    req_op(wsts_pkg::K_POP, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_STEAL, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 3, 16'h0, 1'b0);

    set_workers(8);
    req_op(wsts_pkg::K_PUSH_SPEC, 7, 16'hffff, 1'b0);
    req_op(wsts_pkg::K_PUSH_SPEC, 7, 16'hffff, 1'b1);
    req_op(wsts_pkg::K_PUSH_STEAL, 7, 16'h0000, 1'b1);
    req_op(wsts_pkg::K_PUSH_STEAL, 7, 16'haaaa, 1'b1);
    req_op(wsts_pkg::K_PUSH_STEAL, 7, 16'h5555, 1'b1);
    req_op(wsts_pkg::K_STEAL, 7, 16'h0, 1'b0);
    req_op(wsts_pkg::K_STEAL, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 7, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 7, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 7, 16'h0, 1'b0);
    req_op(wsts_pkg::K_STEAL, 7, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 0, 16'h0, 1'b0);
    req_op(wsts_pkg::K_POP, 0, 16'h0, 1'b0);

    // fill stacks to the brim, then steal from the lowest-numbered worker with stealable work
    for (int i = 0; i < wsts_pkg::Tasks; i++)
      req_op(wsts_pkg::K_PUSH_STEAL, 0, 16'($urandom_range(0, 65535)), 1'b1);
    req_op(wsts_pkg::K_PUSH_STEAL, 0, 16'hbeef, 1'b1);
    req_op(wsts_pkg::K_PUSH_STEAL, 0, 16'hbeef, 1'b0);
    for (int i = 0; i < wsts_pkg::Tasks; i++)
      req_op(wsts_pkg::K_PUSH_SPEC, 2, 16'($urandom_range(0, 65535)), 1'b1);
    req_op(wsts_pkg::K_PUSH_SPEC, 2, 16'hcafe, 1'b1);
    req_op(wsts_pkg::K_STEAL, 1, 16'h0, 1'b0);
    req_op(wsts_pkg::K_STEAL, 1, 16'h0, 1'b0);
    req_op(wsts_pkg::K_STEAL, 3, 16'h0, 1'b0);
    for (int i = 0; i < 20; i++) req_op(wsts_pkg::K_POP, $urandom_range(0, 3), 16'h0, 1'b0);

    random_run(150);
    set_workers(15);
    random_run(200);
    set_workers(2);
    random_run(200);
    set_workers(1);
    random_run(60);
    set_workers(0);
    random_run(40);
    set_workers(5);
    random_run(200);
    set_workers(3);
    random_run(150);
    set_workers(8);
    random_run(100);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results: %0d good pops, %0d steals, %0d full refusals",
             items_sent, board.n_checked, board.n_ok_pop, board.n_steal, board.n_full);
    $display("worker counts 1, 0, 2, 3, 5, 8 and 15 were exercised");
    if (board.errors == 0 && !board.pending())
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
